// File: src/haptic_pattern_sequencer_top_macros.svh
// Assertion macros shared by the haptic pattern sequencer checkers.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef HAPTIC_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define HAPTIC_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("haptic pattern sequencer check failed");

// Next-cycle implication, disabled while reset is high.
`define HPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("haptic pattern sequencer check failed");

`endif

// File: src/hps_pkg.sv
// Shared constants, command codes and the pattern table of the haptic pattern sequencer.
// No dependencies; every other file of the block but the assertion macro header imports this package.
package hps_pkg;

   localparam int STEPS_PER_PATTERN = 10;
   localparam int PERIOD_WIDTH      = 16;
   localparam int TABLE_STEPS       = 10;
   localparam int NUM_PATTERNS      = 6;

   localparam int STEP_WIDTH  = (STEPS_PER_PATTERN > 1) ? $clog2(STEPS_PER_PATTERN) : 1;
   localparam int TICKS_WIDTH = PERIOD_WIDTH + 1;

   // Largest period the counter width can hold, limited to 60000 ticks.
   localparam longint unsigned PERIOD_FULL = (64'd1 << PERIOD_WIDTH) - 64'd1;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_CAP =
      PERIOD_WIDTH'((PERIOD_FULL < 64'd60000) ? PERIOD_FULL : 64'd60000);
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET =
      PERIOD_WIDTH'((PERIOD_FULL < 64'd100) ? PERIOD_FULL : 64'd100);

   // floor(v / 10) = (v * PERIOD_RECIP) >> PERIOD_RECIP_SHIFT for every PERIOD_WIDTH-bit v.
   // The approximation error stays below 1/16, under the 1/10 margin needed.
   localparam int PERIOD_RECIP_SHIFT = PERIOD_WIDTH + 4;
   localparam logic [PERIOD_WIDTH:0] PERIOD_RECIP =
      (PERIOD_WIDTH+1)'((64'd1 << PERIOD_RECIP_SHIFT) / 64'd10 + 64'd1);

   // Command codes carried in the func field.
   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_START      = 3'd1;
   localparam logic [2:0] FUNC_STOP       = 3'd2;
   localparam logic [2:0] FUNC_PAUSE      = 3'd3;
   localparam logic [2:0] FUNC_SPEED_UP   = 3'd4;
   localparam logic [2:0] FUNC_SPEED_DOWN = 3'd5;

   // Drive levels.
   localparam logic [1:0] LEVEL_OFF  = 2'd0;
   localparam logic [1:0] LEVEL_FULL = 2'd1;
   localparam logic [1:0] LEVEL_HALF = 2'd2;

   // One table entry: drive level and motor number.
   typedef struct packed {
      logic [1:0] level;
      logic [2:0] motor;
   } pattern_entry_type;

   localparam pattern_entry_type F0 = '{LEVEL_FULL, 3'd0};
   localparam pattern_entry_type F1 = '{LEVEL_FULL, 3'd1};
   localparam pattern_entry_type F2 = '{LEVEL_FULL, 3'd2};
   localparam pattern_entry_type F3 = '{LEVEL_FULL, 3'd3};
   localparam pattern_entry_type F4 = '{LEVEL_FULL, 3'd4};
   localparam pattern_entry_type F5 = '{LEVEL_FULL, 3'd5};
   localparam pattern_entry_type F6 = '{LEVEL_FULL, 3'd6};
   localparam pattern_entry_type H0 = '{LEVEL_HALF, 3'd0};
   localparam pattern_entry_type H1 = '{LEVEL_HALF, 3'd1};
   localparam pattern_entry_type H2 = '{LEVEL_HALF, 3'd2};
   localparam pattern_entry_type H4 = '{LEVEL_HALF, 3'd4};
   localparam pattern_entry_type H5 = '{LEVEL_HALF, 3'd5};
   localparam pattern_entry_type H6 = '{LEVEL_HALF, 3'd6};

   localparam pattern_entry_type PATTERN_ROM [0:NUM_PATTERNS-1][0:TABLE_STEPS-1] = '{
      '{F2, F3, F4, H1, H0, F2, F3, F4, H6, H5},
      '{F0, F3, F6, H4, H1, F0, F3, F6, H5, H2},
      '{F1, F3, F5, H6, H4, F1, F3, F5, H2, H0},
      '{F4, F3, F2, H5, H6, F4, F3, F2, H0, H1},
      '{F6, F3, F0, H2, H5, F6, F3, F0, H1, H4},
      '{F5, F3, F1, H0, H2, F5, F3, F1, H4, H6}
   };

   // Table lookup. The row is always a valid pattern number; the column is folded
   // into 0..TABLE_STEPS-1 by the caller.
   function automatic pattern_entry_type pattern_lookup(input logic [2:0] row,
                                                        input logic [3:0] col);
      pattern_entry_type entry;
      entry = '0;
      if ((row < 3'(NUM_PATTERNS)) && (col < 4'(TABLE_STEPS))) begin
         entry = PATTERN_ROM[row][col];
      end
      return entry;
   endfunction

endpackage

// File: src/hps_period.sv
// Step period rescaling for speed up (x9/10) and speed down (x11/10), with clamping.
// Depends on hps_pkg for the period width, the limit and the reciprocal of ten.
module hps_period import hps_pkg::*; (
   input  logic [PERIOD_WIDTH-1:0] period_cur,
   output logic [PERIOD_WIDTH-1:0] period_up,
   output logic [PERIOD_WIDTH-1:0] period_down
);

   logic [2*PERIOD_WIDTH:0] recip_prod;
   logic [PERIOD_WIDTH-1:0] tenth;
   logic [PERIOD_WIDTH-1:0] tenth_x10;
   logic                    has_rem;
   logic [PERIOD_WIDTH-1:0] up_raw;
   logic [PERIOD_WIDTH:0]   down_raw;

   // floor(v / 10) by multiplying with a fixed reciprocal.
   assign recip_prod = (2*PERIOD_WIDTH+1)'(period_cur) * (2*PERIOD_WIDTH+1)'(PERIOD_RECIP);
   assign tenth      = PERIOD_WIDTH'(recip_prod >> PERIOD_RECIP_SHIFT);
   assign tenth_x10  = (tenth << 3) + (tenth << 1);
   assign has_rem    = (tenth_x10 != period_cur);

   // floor(9v/10) = v - ceil(v/10); floor(11v/10) = v + floor(v/10).
   assign up_raw   = period_cur - tenth - PERIOD_WIDTH'(has_rem);
   assign down_raw = {1'b0, period_cur} + {1'b0, tenth};

   assign period_up   = (up_raw == '0) ? PERIOD_WIDTH'(1) : up_raw;
   assign period_down = (down_raw > {1'b0, PERIOD_CAP}) ? PERIOD_CAP
                                                         : down_raw[PERIOD_WIDTH-1:0];

endmodule

// File: src/haptic_pattern_sequencer_top.sv
// Haptic pattern sequencer: the result of an item accepted at one clock edge is presented
// from that edge on in the result register.
// Throughput is one item per cycle; the only limit is the single result register,
// which frees itself in the same cycle in which its transfer completes.
// Reset (synchronous, active high) stops playback, clears pause and the step state,
// loads the default period of 100 ticks and empties the result register.
module haptic_pattern_sequencer_top import hps_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_func,
   input  logic [2:0]              req_goal,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_step_valid,
   output logic [2:0]              rsp_off_motor,
   output logic [2:0]              rsp_on_motor,
   output logic [1:0]              rsp_on_level,
   output logic                    rsp_all_off,
   output logic                    rsp_bad_goal,
   output logic [15:0]             rsp_period_now
);

   // Sequencer state.
   logic                    running_ff, running_in;
   logic                    paused_ff, paused_in;
   logic [2:0]              pattern_sel_ff, pattern_sel_in;
   logic [STEP_WIDTH-1:0]   step_index_ff, step_index_in;
   logic [2:0]              last_motor_ff, last_motor_in;
   logic [PERIOD_WIDTH-1:0] step_time_ff, step_time_in;
   logic [TICKS_WIDTH-1:0]  ticks_left_ff, ticks_left_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    step_valid_ff, step_valid_in;
   logic [2:0]              off_motor_ff, off_motor_in;
   logic [2:0]              on_motor_ff, on_motor_in;
   logic [1:0]              on_level_ff, on_level_in;
   logic                    all_off_ff, all_off_in;
   logic                    bad_goal_ff, bad_goal_in;
   logic [PERIOD_WIDTH-1:0] period_now_ff, period_now_in;

   logic                    req_take;
   logic                    rsp_take;
   logic [TICKS_WIDTH-1:0]  ticks_dec;
   logic [3:0]              step_col;
   logic [STEP_WIDTH-1:0]   step_next;
   pattern_entry_type       entry;
   logic [PERIOD_WIDTH-1:0] period_up;
   logic [PERIOD_WIDTH-1:0] period_down;

   // The input is held off only while a finished result waits on a stalled output.
   // When the output transfer completes in the same cycle the slot is reused at once.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   hps_period u_period (
      .period_cur  (step_time_ff),
      .period_up   (period_up),
      .period_down (period_down)
   );

   // The tick counter saturates at zero; ticks count down whether or not a
   // pattern is playing, so paused time still counts toward the next step.
   assign ticks_dec = (ticks_left_ff != '0) ? ticks_left_ff - TICKS_WIDTH'(1) : '0;

   // The step index never exceeds 15, so one compare and subtract folds it into
   // a table column.
   assign step_col = (4'(step_index_ff) >= 4'(TABLE_STEPS))
                   ? 4'(step_index_ff) - 4'(TABLE_STEPS) : 4'(step_index_ff);
   assign step_next = (step_index_ff == STEP_WIDTH'(STEPS_PER_PATTERN - 1))
                    ? '0 : step_index_ff + STEP_WIDTH'(1);
   assign entry = pattern_lookup(pattern_sel_ff, step_col);

   // Next state and result for the item on the input, evaluated in one pass.
   always_comb begin
      running_in     = running_ff;
      paused_in      = paused_ff;
      pattern_sel_in = pattern_sel_ff;
      step_index_in  = step_index_ff;
      last_motor_in  = last_motor_ff;
      step_time_in   = step_time_ff;
      ticks_left_in  = ticks_left_ff;
      step_valid_in  = 1'b0;
      off_motor_in   = 3'd0;
      on_motor_in    = 3'd0;
      on_level_in    = LEVEL_OFF;
      all_off_in     = 1'b0;
      bad_goal_in    = 1'b0;

      case (req_func)
         FUNC_TICK: begin
            ticks_left_in = ticks_dec;
            // A step is due once the counter has run out; a step that became due
            // while paused fires on the first tick after resuming.
            if (running_ff && !paused_ff && (ticks_dec == '0)) begin
               step_valid_in = 1'b1;
               off_motor_in  = last_motor_ff;
               on_motor_in   = entry.motor;
               on_level_in   = entry.level;
               last_motor_in = entry.motor;
               step_index_in = step_next;
               ticks_left_in = TICKS_WIDTH'(step_time_ff) + TICKS_WIDTH'(1);
            end
         end
         FUNC_START: begin
            // A valid goal (re)starts its pattern at step 0 on the next tick;
            // the pause flag is left alone. A bad goal only raises the flag.
            if (req_goal < 3'(NUM_PATTERNS)) begin
               pattern_sel_in = req_goal;
               running_in     = 1'b1;
               step_index_in  = '0;
               ticks_left_in  = TICKS_WIDTH'(1);
            end else begin
               bad_goal_in = 1'b1;
            end
         end
         FUNC_STOP: begin
            // Stop reports all motors off even when nothing was playing.
            running_in = 1'b0;
            all_off_in = 1'b1;
         end
         FUNC_PAUSE: begin
            paused_in = !paused_ff;
         end
         FUNC_SPEED_UP: begin
            step_time_in = period_up;
         end
         FUNC_SPEED_DOWN: begin
            step_time_in = period_down;
         end
         default: begin
            // Unused codes leave the state unchanged and still produce a result.
         end
      endcase

      period_now_in = step_time_in;
   end

   // Every accepted item yields one result; the register empties when its
   // transfer completes and nothing new arrives.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         paused_ff      <= 1'b0;
         pattern_sel_ff <= 3'd0;
         step_index_ff  <= '0;
         last_motor_ff  <= 3'd0;
         step_time_ff   <= PERIOD_RESET;
         ticks_left_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            running_ff     <= running_in;
            paused_ff      <= paused_in;
            pattern_sel_ff <= pattern_sel_in;
            step_index_ff  <= step_index_in;
            last_motor_ff  <= last_motor_in;
            step_time_ff   <= step_time_in;
            ticks_left_ff  <= ticks_left_in;
         end
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (req_take) begin
         step_valid_ff <= step_valid_in;
         off_motor_ff  <= off_motor_in;
         on_motor_ff   <= on_motor_in;
         on_level_ff   <= on_level_in;
         all_off_ff    <= all_off_in;
         bad_goal_ff   <= bad_goal_in;
         period_now_ff <= period_now_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_valid = step_valid_ff;
   assign rsp_off_motor  = off_motor_ff;
   assign rsp_on_motor   = on_motor_ff;
   assign rsp_on_level   = on_level_ff;
   assign rsp_all_off    = all_off_ff;
   assign rsp_bad_goal   = bad_goal_ff;
   assign rsp_period_now = 16'(period_now_ff);

endmodule

// File: src/hps_checker.sv
// Port-level checks for the haptic pattern sequencer, bound to its top level.
// Depends on hps_pkg for command codes and on the shared assertion macro header.
`include "haptic_pattern_sequencer_top_macros.svh"

module hps_checker import hps_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_func,
   input logic [2:0]  req_goal,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_step_valid,
   input logic [2:0]  rsp_off_motor,
   input logic [2:0]  rsp_on_motor,
   input logic [1:0]  rsp_on_level,
   input logic        rsp_all_off,
   input logic        rsp_bad_goal,
   input logic [15:0] rsp_period_now
);

   // A stalled result keeps its contents.
   `HPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_period_now) && $stable(rsp_step_valid) && $stable(rsp_on_motor))

   // An accepted stop shows up next cycle as an all-off result without a step.
   `HPS_ASSERT_NEXT(a_stop_result, req_valid && !req_stall && req_func == FUNC_STOP, rsp_valid && rsp_all_off && !rsp_step_valid)

   // A start with a goal beyond the table is flagged in its result.
   `HPS_ASSERT_NEXT(a_bad_goal, req_valid && !req_stall && req_func == FUNC_START && req_goal >= 3'(NUM_PATTERNS), rsp_valid && rsp_bad_goal)

   // A step always drives at a real level; without a step the motor fields are zero.
   `HPS_ASSERT_NOW(a_step_fields, rsp_valid, rsp_step_valid ? (rsp_on_level != LEVEL_OFF) : (rsp_on_level == LEVEL_OFF && rsp_on_motor == 3'd0 && rsp_off_motor == 3'd0))

   // The reported period never reaches zero.
   `HPS_ASSERT_NOW(a_period_nonzero, rsp_valid, rsp_period_now != 16'd0)

endmodule

bind haptic_pattern_sequencer_top hps_checker u_hps_checker (.*);

// File: bench/hps_checker.sv
`timescale 1ns / 1ps
// Checker for the haptic pattern sequencer: watches both channels, predicts each result
// and compares it with what the block returns. Depends on hps_pkg for codes and limits.
module hps_scoreboard import hps_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [2:0]              req_func,
   input  logic [2:0]              req_goal,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_step_valid,
   input  logic [2:0]              rsp_off_motor,
   input  logic [2:0]              rsp_on_motor,
   input  logic [1:0]              rsp_on_level,
   input  logic                    rsp_all_off,
   input  logic                    rsp_bad_goal,
   input  logic [15:0]             rsp_period_now,
   output int unsigned             mismatch_count,
   output int unsigned             outstanding,
   output int unsigned             result_count,
   output int unsigned             step_count,
   output int unsigned             stop_count,
   output int unsigned             reject_count
);

   typedef struct packed {
      logic        step_valid;
      logic [2:0]  off_motor;
      logic [2:0]  on_motor;
      logic [1:0]  on_level;
      logic        all_off;
      logic        bad_goal;
      logic [15:0] period_now;
   } sequencer_result_type;

   // Motor order of each pattern; every pattern shares the same level rhythm.
   localparam int MOTOR_SEQ [0:5][0:9] = '{
      '{2, 3, 4, 1, 0, 2, 3, 4, 6, 5},
      '{0, 3, 6, 4, 1, 0, 3, 6, 5, 2},
      '{1, 3, 5, 6, 4, 1, 3, 5, 2, 0},
      '{4, 3, 2, 5, 6, 4, 3, 2, 0, 1},
      '{6, 3, 0, 2, 5, 6, 3, 0, 1, 4},
      '{5, 3, 1, 0, 2, 5, 3, 1, 4, 6}
   };
   localparam logic [1:0] LEVEL_SEQ [0:9] = '{
      LEVEL_FULL, LEVEL_FULL, LEVEL_FULL, LEVEL_HALF, LEVEL_HALF,
      LEVEL_FULL, LEVEL_FULL, LEVEL_FULL, LEVEL_HALF, LEVEL_HALF
   };

   logic                    playing;
   logic                    held;
   logic [2:0]              pattern;
   logic [3:0]              position;
   logic [2:0]              last_on;
   logic [PERIOD_WIDTH-1:0] period;
   int unsigned             ticks_due;

   sequencer_result_type awaited_results [$];

   function automatic logic [PERIOD_WIDTH-1:0] rescale_period(input logic [PERIOD_WIDTH-1:0] p,
                                                              input int unsigned tenths);
      longint unsigned v;
      v = (longint'(p) * tenths) / 10;
      if (v < 1) v = 1;
      if (v > PERIOD_CAP) v = PERIOD_CAP;
      return v[PERIOD_WIDTH-1:0];
   endfunction

   task automatic advance_sequencer(input logic [2:0] func, input logic [2:0] goal,
                                    output sequencer_result_type res);
      logic [2:0] motor;
      res = '0;
      case (func)
         FUNC_TICK: begin
            if (ticks_due != 0) ticks_due--;
            if (playing && !held && ticks_due == 0) begin
               motor = 3'(MOTOR_SEQ[pattern][position % TABLE_STEPS]);
               res.step_valid = 1'b1;
               res.off_motor  = last_on;
               res.on_motor   = motor;
               res.on_level   = LEVEL_SEQ[position % TABLE_STEPS];
               last_on        = motor;
               position       = (position == 4'(STEPS_PER_PATTERN - 1)) ? 4'd0 : position + 4'd1;
               ticks_due      = period + 1;
            end
         end
         FUNC_START: begin
            if (goal < NUM_PATTERNS) begin
               pattern   = goal;
               playing   = 1'b1;
               position  = 4'd0;
               ticks_due = 1;
            end else begin
               res.bad_goal = 1'b1;
            end
         end
         FUNC_STOP: begin
            playing     = 1'b0;
            res.all_off = 1'b1;
         end
         FUNC_PAUSE:      held = !held;
         FUNC_SPEED_UP:   period = rescale_period(period, 9);
         FUNC_SPEED_DOWN: period = rescale_period(period, 11);
         default: ;
      endcase
      res.period_now = 16'(period);
   endtask

   task automatic report_mismatch(input string what, input sequencer_result_type want,
                                  input sequencer_result_type seen);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s at %0t: expected sv=%0b off=%0d on=%0d lvl=%0d all_off=%0b bad=%0b per=%0d",
                  what, $realtime, want.step_valid, want.off_motor, want.on_motor,
                  want.on_level, want.all_off, want.bad_goal, want.period_now);
         $display("   got sv=%0b off=%0d on=%0d lvl=%0d all_off=%0b bad=%0b per=%0d",
                  seen.step_valid, seen.off_motor, seen.on_motor, seen.on_level,
                  seen.all_off, seen.bad_goal, seen.period_now);
      end
   endtask

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      result_count   = 0;
      step_count     = 0;
      stop_count     = 0;
      reject_count   = 0;
   end

   // Results are retired before the new item is predicted: a result never belongs to the
   // item accepted at the same edge.
   always @(posedge clock) begin : watch_channels
      sequencer_result_type seen;
      sequencer_result_type want;
      if (reset) begin
         playing   = 1'b0;
         held      = 1'b0;
         pattern   = '0;
         position  = '0;
         last_on   = '0;
         period    = PERIOD_RESET;
         ticks_due = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_step_valid, rsp_off_motor, rsp_on_motor, rsp_on_level,
                    rsp_all_off, rsp_bad_goal, rsp_period_now};
            result_count++;
            if (awaited_results.size() == 0) begin
               report_mismatch("Unexpected result", '0, seen);
            end else begin
               want = awaited_results.pop_front();
               if (want !== seen) report_mismatch("Result mismatch", want, seen);
               step_count   += want.step_valid;
               stop_count   += want.all_off;
               reject_count += want.bad_goal;
            end
         end
         if (req_valid && !req_stall) begin
            advance_sequencer(req_func, req_goal, want);
            awaited_results.insert(awaited_results.size(), want);
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top of the haptic pattern sequencer testbench: clock, reset, stimulus and the verdict.
// Depends on hps_pkg, haptic_pattern_sequencer_top and the hps_scoreboard module.
module tb;
   import hps_pkg::*;

   // The func field has two codes the block must ignore; they are not ticks.
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   // Number of counted items in the random part.
   localparam int RANDOM_ITEMS = 650;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_func;
   logic [2:0]  req_goal;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_step_valid;
   logic [2:0]  rsp_off_motor;
   logic [2:0]  rsp_on_motor;
   logic [1:0]  rsp_on_level;
   logic        rsp_all_off;
   logic        rsp_bad_goal;
   logic [15:0] rsp_period_now;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned result_count;
   int unsigned step_count;
   int unsigned stop_count;
   int unsigned reject_count;

   // When gaps_on is low, neither side idles; this gives one long back-to-back stretch.
   logic        gaps_on = 1'b1;
   int unsigned played;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   haptic_pattern_sequencer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_goal       (req_goal),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_step_valid (rsp_step_valid),
      .rsp_off_motor  (rsp_off_motor),
      .rsp_on_motor   (rsp_on_motor),
      .rsp_on_level   (rsp_on_level),
      .rsp_all_off    (rsp_all_off),
      .rsp_bad_goal   (rsp_bad_goal),
      .rsp_period_now (rsp_period_now)
   );

   hps_scoreboard u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_goal       (req_goal),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_step_valid (rsp_step_valid),
      .rsp_off_motor  (rsp_off_motor),
      .rsp_on_motor   (rsp_on_motor),
      .rsp_on_level   (rsp_on_level),
      .rsp_all_off    (rsp_all_off),
      .rsp_bad_goal   (rsp_bad_goal),
      .rsp_period_now (rsp_period_now),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .result_count   (result_count),
      .step_count     (step_count),
      .stop_count     (stop_count),
      .reject_count   (reject_count)
   );

   // The result side stalls at random on about a third of the cycles. It changes only at
   // the falling edge, so the block sees a settled value at every rising edge.
   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(0, 99) < 35);
   end

   // Offers one item and returns at the falling edge after its transfer. Random gaps come
   // first, with valid low; once valid is high the payload is held until the block takes it.
   // Valid is only written at falling edges, and never twice in one of them.
   task automatic send_item(input logic [2:0] func, input logic [2:0] goal);
      logic taken;
      while (gaps_on && $urandom_range(0, 99) < 35) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_func  = func;
      req_goal  = goal;
      do begin
         @(posedge clock);
         taken = !req_stall;
         @(negedge clock);
      end while (!taken);
      // The ignored codes do not count toward the length of the random part.
      if (func <= FUNC_SPEED_DOWN) played++;
   endtask

   // Any code, any goal: this also reaches the ignored codes and the unused goal bits.
   task automatic noise_item();
      send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
   endtask

   // Run-away guard: far beyond the slowest legal run of this stimulus.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int run_len;
      int pick;
      int k;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = FUNC_TICK;
      req_goal  = '0;
      played    = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // Directed part. Nothing plays at first, so a tick must not step and a stop still
      // reports all motors off. Two pause toggles cancel out. The ignored codes and both
      // out-of-range goals must leave the state alone.
      send_item(FUNC_TICK, 3'd0);
      send_item(FUNC_STOP, 3'd7);
      send_item(FUNC_PAUSE, 3'd0);
      send_item(FUNC_PAUSE, 3'd0);
      send_item(FUNC_UNUSED_LO, 3'd7);
      send_item(FUNC_UNUSED_HI, 3'd0);
      send_item(FUNC_START, 3'(NUM_PATTERNS));
      send_item(FUNC_START, 3'(NUM_PATTERNS + 1));
      // First step comes on the first tick after start; the next one is far away.
      send_item(FUNC_START, 3'd0);
      send_item(FUNC_TICK, 3'd7);
      send_item(FUNC_TICK, 3'd0);
      // A restart while paused keeps the pause; the step is held until resume and then
      // comes on the first tick, since it is already overdue.
      send_item(FUNC_PAUSE, 3'd0);
      send_item(FUNC_START, 3'd5);
      send_item(FUNC_TICK, 3'd0);
      send_item(FUNC_PAUSE, 3'd0);
      send_item(FUNC_TICK, 3'd0);
      send_item(FUNC_STOP, 3'd0);
      send_item(FUNC_TICK, 3'd0);
      // The remaining patterns each get their first step; the previous motor goes off.
      for (k = 1; k < NUM_PATTERNS - 1; k++) begin
         send_item(FUNC_START, 3'(k));
         send_item(FUNC_TICK, 3'd0);
      end
      send_item(FUNC_SPEED_UP, 3'd0);
      send_item(FUNC_SPEED_DOWN, 3'd0);

      played = 0;

      // Climb: slow down until the period sits at its upper clamp for a while.
      repeat (85) begin
         if ($urandom_range(0, 3) == 0) noise_item();
         send_item(FUNC_SPEED_DOWN, 3'($urandom_range(0, 7)));
      end

      // Descent, run back to back on both sides: speed up from the clamp to a short
      // period. Below ten ticks a slow-down can no longer raise the period, so the
      // remaining run plays patterns at short periods, down to the lower clamp.
      gaps_on = 1'b0;
      repeat (82) begin
         if ($urandom_range(0, 3) == 0) noise_item();
         send_item(FUNC_SPEED_UP, 3'($urandom_range(0, 7)));
      end
      gaps_on = 1'b1;

      // Play: mostly a start followed by a run of ticks, with pause pairs (ticks while
      // paused still count), speed changes, wrap past the last step and an optional stop.
      // The rest is single random items.
      while (played < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 70) begin
            send_item(FUNC_START, 3'($urandom_range(0, NUM_PATTERNS - 1)));
            run_len = $urandom_range(1, 60);
            repeat (run_len) begin
               pick = $urandom_range(0, 99);
               if (pick < 4) begin
                  send_item(FUNC_PAUSE, 3'($urandom_range(0, 7)));
                  repeat ($urandom_range(1, 15)) send_item(FUNC_TICK, 3'($urandom_range(0, 7)));
                  send_item(FUNC_PAUSE, 3'($urandom_range(0, 7)));
               end else if (pick < 6) begin
                  send_item(FUNC_SPEED_UP, 3'($urandom_range(0, 7)));
               end else if (pick < 8) begin
                  send_item(FUNC_SPEED_DOWN, 3'($urandom_range(0, 7)));
               end else begin
                  send_item(FUNC_TICK, 3'($urandom_range(0, 7)));
               end
            end
            if ($urandom_range(0, 1) == 1) send_item(FUNC_STOP, 3'($urandom_range(0, 7)));
         end else begin
            noise_item();
         end
      end
      req_valid = 1'b0;

      // Drain: every prediction must be matched, then the bench waits on to catch a stray result.
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Covered %0d results with %0d motor steps, %0d stops and %0d rejected goals,",
               result_count, step_count, stop_count, reject_count);
      $display("sweeping the period between both clamps; %0d mismatches.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: haptic_pattern_sequencer_top.f
+incdir+src
src/hps_pkg.sv
src/hps_period.sv
src/haptic_pattern_sequencer_top.sv
src/hps_checker.sv
bench/hps_checker.sv
bench/tb.sv
